// ===== rtl/spps_pkg.sv =====
// Package: shared types and constants for the strict-priority scheduler.
package spps_pkg;

    localparam int NUM_PRIORITIES_DEF = 8;
    localparam int MAX_PACKETS_DEF = 15;
    localparam int SEND_MAX_DEF = 64;

    localparam int ID_W = 16;
    localparam int PRIO_FIELD_W = 3;
    localparam int LIMIT_W = 7;

    localparam logic KIND_RECV = 1'b0;
    localparam logic KIND_SEND = 1'b1;

    typedef struct packed {
        logic                    kind;
        logic [PRIO_FIELD_W-1:0] prio;
        logic [ID_W-1:0]         packet_id;
        logic [LIMIT_W-1:0]      limit;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPEND,
        ST_COMPACT_RD,
        ST_COMPACT_WR,
        ST_SEND_PICK,
        ST_SEND_RD,
        ST_SEND_OUT
    } eng_state_t;

endpackage

// ===== rtl/strict_priority_packet_scheduler_unit.sv =====
// Top level: strict-priority packet scheduler with decoupled front and back parts.
// Input channel s_*: kind 0 appends s_packet_id to the queue of s_priority_req;
// kind 1 sends up to s_send_limit handles, highest non-empty priority first.
// Result channel m_*: one item per sent handle, m_last marks the final one of a send.
// A receive that overflows its queue keeps every second entry, oldest first,
// and the back part compacts the kept entries in place before it takes the
// next command.
// A send produces each result by a read of the handle memory followed by the
// output register load, and holds while a result waits on m_ready.
// A two-entry command queue lets the input side accept while the back part works.
// Sends with nothing queued or a zero limit give no results.
// Reset (synchronous, aresetn low) empties every queue and the command queue.
// When m_ready is low the back part holds its result and stops before loading the
// next one; the command queue then fills and s_ready drops.
module strict_priority_packet_scheduler_unit #(
    parameter int NUM_PRIORITIES = spps_pkg::NUM_PRIORITIES_DEF,
    parameter int MAX_PACKETS = spps_pkg::MAX_PACKETS_DEF,
    parameter int SEND_MAX = spps_pkg::SEND_MAX_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_kind,
    input  logic [spps_pkg::PRIO_FIELD_W-1:0] s_priority_req,
    input  logic [spps_pkg::ID_W-1:0]         s_packet_id,
    input  logic [spps_pkg::LIMIT_W-1:0]      s_send_limit,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [spps_pkg::ID_W-1:0]         m_out_packet_id,
    output logic [spps_pkg::PRIO_FIELD_W-1:0] m_out_priority,
    output logic                              m_last
);
    import spps_pkg::*;

    cmd_t cmd;
    logic cmd_valid, cmd_ready;

    spps_front #(
        .NUM_PRIORITIES(NUM_PRIORITIES),
        .SEND_MAX(SEND_MAX)
    ) u_front (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_kind(s_kind),
        .s_priority_req(s_priority_req),
        .s_packet_id(s_packet_id),
        .s_send_limit(s_send_limit),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd(cmd)
    );

    spps_engine #(
        .NUM_PRIORITIES(NUM_PRIORITIES),
        .MAX_PACKETS(MAX_PACKETS)
    ) u_engine (
        .aclk(aclk),
        .aresetn(aresetn),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd(cmd),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_out_packet_id(m_out_packet_id),
        .m_out_priority(m_out_priority),
        .m_last(m_last)
    );

endmodule

// ===== rtl/spps_front.sv =====
// Front part: accepts items, drops invalid ones, clamps send limits, queues commands.
module spps_front #(
    parameter int NUM_PRIORITIES = spps_pkg::NUM_PRIORITIES_DEF,
    parameter int SEND_MAX = spps_pkg::SEND_MAX_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_kind,
    input  logic [spps_pkg::PRIO_FIELD_W-1:0] s_priority_req,
    input  logic [spps_pkg::ID_W-1:0]         s_packet_id,
    input  logic [spps_pkg::LIMIT_W-1:0]      s_send_limit,
    output logic                              cmd_valid,
    input  logic                              cmd_ready,
    output spps_pkg::cmd_t                    cmd
);
    import spps_pkg::*;

    localparam int DEPTH = 2;

    cmd_t       fifo_reg [DEPTH];
    logic       wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       in_cmd;
    logic       keep, push, pop;
    logic [LIMIT_W-1:0] lim;

    always_comb begin
        lim = s_send_limit;
        if (32'(s_send_limit) > SEND_MAX) begin
            lim = LIMIT_W'(SEND_MAX);
        end
        in_cmd.kind = s_kind;
        in_cmd.prio = s_priority_req;
        in_cmd.packet_id = s_packet_id;
        in_cmd.limit = lim;
        if (s_kind == KIND_RECV) begin
            keep = (32'(s_priority_req) < NUM_PRIORITIES);
        end else begin
            keep = (lim != '0);
        end
    end

    assign s_ready = (cnt_reg != 2'(DEPTH));
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd = fifo_reg[rptr_reg];
    assign push = s_valid && s_ready && keep;
    assign pop = cmd_valid && cmd_ready;

    always_comb begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== rtl/spps_engine.sv =====
// Back part: per-priority circular queues in memory, compaction and send sequencing.
module spps_engine #(
    parameter int NUM_PRIORITIES = spps_pkg::NUM_PRIORITIES_DEF,
    parameter int MAX_PACKETS = spps_pkg::MAX_PACKETS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  spps_pkg::cmd_t                    cmd,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [spps_pkg::ID_W-1:0]         m_out_packet_id,
    output logic [spps_pkg::PRIO_FIELD_W-1:0] m_out_priority,
    output logic                              m_last
);
    import spps_pkg::*;

    localparam int SLOTS = MAX_PACKETS + 1;
    localparam int PW = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int DEPTH = NUM_PRIORITIES * SLOTS;
    localparam int AW = $clog2(DEPTH);

    logic [ID_W-1:0] mem [DEPTH];
    logic [ID_W-1:0] rdata_reg;

    logic [SW-1:0] head_reg [NUM_PRIORITIES];
    logic [CW-1:0] count_reg [NUM_PRIORITIES];

    eng_state_t state_reg, state_next;
    logic [PW-1:0] prio_reg, prio_next;
    logic [ID_W-1:0] id_reg, id_next;
    logic [LIMIT_W-1:0] left_reg, left_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] kept_reg, kept_next;

    logic out_valid_reg, out_valid_next;
    logic [ID_W-1:0] out_id_reg, out_id_next;
    logic [PRIO_FIELD_W-1:0] out_prio_reg, out_prio_next;
    logic out_last_reg, out_last_next;

    logic wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [ID_W-1:0] wr_data;

    logic head_we, count_we;
    logic [SW-1:0] head_wv;
    logic [CW-1:0] count_wv;

    logic any_busy;
    logic [PW-1:0] top;
    logic [NUM_PRIORITIES-1:0] nz;

    function automatic logic [AW-1:0] addr_of(input logic [PW-1:0] p, input logic [SW-1:0] h,
                                              input logic [CW-1:0] pos);
        logic [SW:0] s;
        logic [SW:0] w;
        s = {1'b0, h} + (SW+1)'(pos);
        w = (s >= (SW+1)'(SLOTS)) ? s - (SW+1)'(SLOTS) : s;
        return AW'(32'(p) * SLOTS + 32'(w));
    endfunction

    always_comb begin
        for (int i = 0; i < NUM_PRIORITIES; i++) begin
            nz[i] = (count_reg[i] != '0);
        end
    end

    always_comb begin
        any_busy = |nz;
        top = '0;
        for (int i = 0; i < NUM_PRIORITIES; i++) begin
            if (nz[i]) begin
                top = PW'(i);
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_out_packet_id = out_id_reg;
    assign m_out_priority = out_prio_reg;
    assign m_last = out_last_reg;

    always_comb begin
        state_next = state_reg;
        prio_next = prio_reg;
        id_next = id_reg;
        left_next = left_reg;
        k_next = k_reg;
        kept_next = kept_reg;
        out_valid_next = out_valid_reg;
        out_id_next = out_id_reg;
        out_prio_next = out_prio_reg;
        out_last_next = out_last_reg;
        cmd_ready = 1'b0;
        wr_en = 1'b0;
        rd_en = 1'b0;
        wr_addr = '0;
        rd_addr = '0;
        wr_data = id_reg;
        head_we = 1'b0;
        head_wv = '0;
        count_we = 1'b0;
        count_wv = '0;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    prio_next = PW'(cmd.prio);
                    id_next = cmd.packet_id;
                    left_next = cmd.limit;
                    state_next = (cmd.kind == KIND_RECV) ? ST_APPEND : ST_SEND_PICK;
                end
            end
            ST_APPEND: begin
                wr_en = 1'b1;
                wr_addr = addr_of(prio_reg, head_reg[prio_reg], count_reg[prio_reg]);
                wr_data = id_reg;
                count_we = 1'b1;
                if (32'(count_reg[prio_reg]) + 1 > MAX_PACKETS) begin
                    kept_next = CW'((32'(count_reg[prio_reg]) + 2) / 2);
                    count_wv = CW'((32'(count_reg[prio_reg]) + 2) / 2);
                    k_next = CW'(1);
                    state_next = ST_COMPACT_RD;
                end else begin
                    count_wv = count_reg[prio_reg] + CW'(1);
                    state_next = ST_IDLE;
                end
            end
            ST_COMPACT_RD: begin
                if (k_reg >= kept_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    rd_en = 1'b1;
                    rd_addr = addr_of(prio_reg, head_reg[prio_reg], CW'({k_reg, 1'b0}));
                    state_next = ST_COMPACT_WR;
                end
            end
            ST_COMPACT_WR: begin
                wr_en = 1'b1;
                wr_addr = addr_of(prio_reg, head_reg[prio_reg], k_reg);
                wr_data = rdata_reg;
                k_next = k_reg + CW'(1);
                state_next = ST_COMPACT_RD;
            end
            ST_SEND_PICK: begin
                if (!any_busy || left_reg == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    prio_next = top;
                    rd_en = 1'b1;
                    rd_addr = addr_of(top, head_reg[top], '0);
                    head_we = 1'b1;
                    head_wv = (32'(head_reg[top]) == SLOTS - 1) ? '0 : head_reg[top] + SW'(1);
                    count_we = 1'b1;
                    count_wv = count_reg[top] - CW'(1);
                    left_next = left_reg - LIMIT_W'(1);
                    state_next = ST_SEND_OUT;
                end
            end
            ST_SEND_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_id_next = rdata_reg;
                    out_prio_next = PRIO_FIELD_W'(prio_reg);
                    out_last_next = (left_reg == '0) || !any_busy;
                    state_next = ST_SEND_PICK;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_PRIORITIES; i++) begin
                head_reg[i] <= '0;
                count_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            if (head_we) begin
                head_reg[prio_next] <= head_wv;
            end
            if (count_we) begin
                count_reg[prio_next] <= count_wv;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prio_reg <= prio_next;
        id_reg <= id_next;
        left_reg <= left_next;
        k_reg <= k_next;
        kept_reg <= kept_next;
        out_id_reg <= out_id_next;
        out_prio_reg <= out_prio_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/spps_checker.sv =====
// Checker: port-level properties of the scheduler, bound to the top level.
module spps_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_out_packet_id,
    input logic [2:0]  m_out_priority,
    input logic        m_last
);
    a_no_out_in_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_packet_id) && $stable(m_last)
            && $stable(m_out_priority))
        else $error("stalled result changed");

    a_ready_after_reset: assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready after reset");

endmodule

bind strict_priority_packet_scheduler_unit spps_checker u_spps_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_out_packet_id(m_out_packet_id),
    .m_out_priority(m_out_priority),
    .m_last(m_last)
);

// ===== verif/strict_priority_packet_scheduler_unit_test.sv =====
// Testbench for the strict-priority packet scheduler: directed and random items checked against a queue predictor.
`timescale 1ns / 100ps

module strict_priority_packet_scheduler_unit_test;
    import spps_pkg::*;

    localparam int NPRIO = NUM_PRIORITIES_DEF;
    localparam int MAXPKT = MAX_PACKETS_DEF;
    localparam int SMAX = SEND_MAX_DEF;

    typedef struct packed {
        logic [ID_W-1:0]         packet_id;
        logic [PRIO_FIELD_W-1:0] prio;
        logic                    last;
    } sent_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_kind;
    logic [PRIO_FIELD_W-1:0] s_priority_req;
    logic [ID_W-1:0]         s_packet_id;
    logic [LIMIT_W-1:0]      s_send_limit;
    logic                    m_valid;
    logic                    m_ready;
    logic [ID_W-1:0]         m_out_packet_id;
    logic [PRIO_FIELD_W-1:0] m_out_priority;
    logic                    m_last;

    logic [ID_W-1:0] prio_queue[NPRIO][$];
    sent_t           expected_sends[$];
    int              mismatches;
    int              results_seen;
    int              items_sent;
    bit              stall_enable;

    strict_priority_packet_scheduler_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_priority_req(s_priority_req), .s_packet_id(s_packet_id),
        .s_send_limit(s_send_limit),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_packet_id(m_out_packet_id), .m_out_priority(m_out_priority),
        .m_last(m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

    function automatic void predict_item(logic kind, logic [PRIO_FIELD_W-1:0] prio,
                                         logic [ID_W-1:0] id, logic [LIMIT_W-1:0] limit);
        int    lim;
        int    p;
        int    n;
        sent_t r;
        logic [ID_W-1:0] kept[$];
        if (kind == KIND_RECV) begin
            if (prio >= NPRIO) return;
            prio_queue[prio].push_back(id);
            if (prio_queue[prio].size() > MAXPKT) begin
                kept = {};
                for (int k = 0; k < prio_queue[prio].size(); k += 2)
                    kept.push_back(prio_queue[prio][k]);
                prio_queue[prio] = kept;
            end
            return;
        end
        lim = (limit > SMAX) ? SMAX : limit;
        n = 0;
        while (n < lim) begin
            p = -1;
            for (int q = NPRIO - 1; q >= 0; q--)
                if (p < 0 && prio_queue[q].size() != 0) p = q;
            if (p < 0) break;
            r.packet_id = prio_queue[p].pop_front();
            r.prio = p[PRIO_FIELD_W-1:0];
            r.last = 1'b0;
            expected_sends.push_back(r);
            n++;
        end
        if (n > 0) expected_sends[$].last = 1'b1;
    endfunction

    task automatic send_item(logic kind, logic [PRIO_FIELD_W-1:0] prio,
                             logic [ID_W-1:0] id, logic [LIMIT_W-1:0] limit);
        int gap;
        gap = stall_enable ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_priority_req <= prio;
        s_packet_id <= id;
        s_send_limit <= limit;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_item(kind, prio, id, limit);
        items_sent++;
    endtask

    task automatic end_items;
        s_valid <= 1'b0;
    endtask

    // stall the result side per item
    initial begin
        int wait_cycles;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                wait_cycles = stall_enable ? $urandom_range(0, 17) : 0;
                if (wait_cycles > 0) begin
                    m_ready <= 1'b0;
                    repeat (wait_cycles) @(posedge aclk);
                end
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        sent_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_sends.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item id=%h prio=%0d last=%b",
                             m_out_packet_id, m_out_priority, m_last);
            end else begin
                exp_r = expected_sends.pop_front();
                if (exp_r.packet_id !== m_out_packet_id || exp_r.prio !== m_out_priority
                    || exp_r.last !== m_last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp id=%h prio=%0d last=%b, got id=%h prio=%0d last=%b",
                                 exp_r.packet_id, exp_r.prio, exp_r.last,
                                 m_out_packet_id, m_out_priority, m_last);
                end
            end
        end
    end

    task automatic test_edge_fields;
        send_item(KIND_SEND, 3'd0, 16'h0000, 7'd5);
        send_item(KIND_RECV, 3'd0, 16'h0000, 7'd0);
        send_item(KIND_RECV, 3'd7, 16'hFFFF, 7'd127);
        send_item(KIND_RECV, 3'd3, 16'hA5A5, 7'd64);
        send_item(KIND_SEND, 3'd7, 16'hFFFF, 7'd0);
        send_item(KIND_SEND, 3'd5, 16'h1234, 7'd1);
        send_item(KIND_SEND, 3'd0, 16'h0000, 7'd127);
        send_item(KIND_SEND, 3'd0, 16'h0000, 7'd3);
    endtask

    task automatic test_compaction;
        for (int i = 0; i < 16; i++)
            send_item(KIND_RECV, 3'd6, 16'(16'h6000 + i), 7'($urandom));
        send_item(KIND_SEND, 3'd0, 16'h0, 7'd64);
    endtask

    task automatic test_random_traffic;
        int r;
        for (int i = 0; i < 60; i++) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                send_item(KIND_RECV, 3'($urandom), 16'($urandom), 7'($urandom));
            else if (r < 95)
                send_item(KIND_SEND, 3'($urandom), 16'($urandom),
                          7'($urandom_range(0, 12)));
            else
                send_item(KIND_SEND, 3'($urandom), 16'($urandom), 7'($urandom_range(0, 127)));
        end
        send_item(KIND_SEND, 3'd0, 16'h0, 7'd127);
        send_item(KIND_SEND, 3'd0, 16'h0, 7'd127);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_kind = 1'b0;
        s_priority_req = '0;
        s_packet_id = '0;
        s_send_limit = '0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        stall_enable = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_edge_fields();
        test_compaction();
        stall_enable = 1'b1;
        test_random_traffic();
        stall_enable = 1'b0;
        test_random_traffic();
        end_items();
        while (expected_sends.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("covered %0d items in and %0d packets out, with compaction and idling",
                 items_sent, results_seen);
        if (mismatches == 0 && expected_sends.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
